// ===== design/lpr_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
package lpr_pkg;

   localparam int FRAMES      = 16;
   localparam int FRAME_BITS  = 4;
   localparam int PAGE_BITS   = 16;
   localparam int COUNT_BITS  = 16;
   localparam int CFG_BITS    = 5;
   localparam int GROUP_SIZE  = 4;
   localparam int GROUPS      = FRAMES / GROUP_SIZE;

   localparam logic [FRAME_BITS-1:0] RANK_MAX   = FRAME_BITS'(FRAMES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [CFG_BITS-1:0]   FRAMES_CFG = CFG_BITS'(FRAMES);
   localparam logic [CFG_BITS-1:0]   FRAMES_ONE = CFG_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } lpr_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } lpr_cmd_type;

endpackage

// ===== design/lpr_req_if.sv =====
// Request and response channel interfaces of the LRU page replacement block.
interface lpr_req_if;
   logic                           valid;
   logic                           ready;
   logic [lpr_pkg::PAGE_BITS-1:0]  page_number;
   logic                           last_reference;

   modport source (output valid, output page_number, output last_reference, input ready);
   modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

interface lpr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [lpr_pkg::FRAME_BITS-1:0] frame_index;
   logic                           evicted_valid;
   logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page;
   logic [lpr_pkg::COUNT_BITS-1:0] fault_count;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_count, output ready);
endinterface

// ===== design/lpr_ctrl.sv =====
// Controller state machine: sequences lookup and update of one request at a time.
module lpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lpr_pkg::lpr_cmd_type cmd
);

   lpr_pkg::lpr_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lpr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = req_valid && req_ready;
      cmd.lookup  = (state_ff == lpr_pkg::ST_LOOKUP);
      cmd.update  = (state_ff == lpr_pkg::ST_UPDATE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpr_pkg::ST_IDLE: begin
            if (req_valid) state_in = lpr_pkg::ST_LOOKUP;
         end
         lpr_pkg::ST_LOOKUP: begin
            state_in = lpr_pkg::ST_UPDATE;
         end
         lpr_pkg::ST_UPDATE: begin
            // The result register must be free before the frame state is committed.
            if (out_free) state_in = lpr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lpr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == lpr_pkg::ST_LOOKUP)
      else $error("accepted request did not enter lookup");

   a_lookup_to_update: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> state_ff == lpr_pkg::ST_UPDATE)
      else $error("lookup not followed by update");

   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not present a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.update)
      else $error("response overwritten while stalled");

endmodule

// ===== design/lpr_dp.sv =====
// Datapath: frame table, recency ranks, fault counter and response register.
module lpr_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  lpr_pkg::lpr_cmd_type             cmd,
   input  logic                             csr_wr_en,
   input  logic [lpr_pkg::CFG_BITS-1:0]     csr_wr_data,
   input  logic [lpr_pkg::PAGE_BITS-1:0]    req_page_number,
   input  logic                             req_last_reference,
   output logic                             rsp_hit,
   output logic [lpr_pkg::FRAME_BITS-1:0]   rsp_frame_index,
   output logic                             rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_BITS-1:0]    rsp_evicted_page,
   output logic [lpr_pkg::COUNT_BITS-1:0]   rsp_fault_count
);

   localparam int FB = lpr_pkg::FRAME_BITS;

   // Frame table and policy state.
   logic [lpr_pkg::PAGE_BITS-1:0]  page_ff [lpr_pkg::FRAMES];
   logic [lpr_pkg::FRAMES-1:0]     valid_ff, valid_in;
   logic [FB-1:0]                  rank_ff [lpr_pkg::FRAMES];
   logic [FB-1:0]                  rank_in [lpr_pkg::FRAMES];
   logic [lpr_pkg::COUNT_BITS-1:0] faults_ff, faults_in;
   logic [lpr_pkg::CFG_BITS-1:0]   frames_ff, frames_in;

   // Captured request.
   logic [lpr_pkg::PAGE_BITS-1:0]  in_page_ff;
   logic                           in_last_ff;

   // Lookup stage results.
   logic [lpr_pkg::FRAMES-1:0]     match_ff, match_in;
   logic [lpr_pkg::FRAMES-1:0]     empty_ff, empty_in;
   logic [FB-1:0]                  grp_best_ff [lpr_pkg::GROUPS];
   logic [FB-1:0]                  grp_best_in [lpr_pkg::GROUPS];
   logic [FB-1:0]                  grp_idx_ff  [lpr_pkg::GROUPS];
   logic [FB-1:0]                  grp_idx_in  [lpr_pkg::GROUPS];

   // Response register.
   logic                           hit_out_ff;
   logic [FB-1:0]                  idx_out_ff;
   logic                           ev_out_ff;
   logic [lpr_pkg::PAGE_BITS-1:0]  evp_out_ff;
   logic [lpr_pkg::COUNT_BITS-1:0] fc_out_ff;

   logic [lpr_pkg::CFG_BITS-1:0]   n_eff;
   logic [lpr_pkg::FRAMES-1:0]     managed;

   logic                           hit_any, empty_any, evict, limit_all;
   logic [FB-1:0]                  hit_idx, empty_idx, victim_idx, victim_best;
   logic [FB-1:0]                  slot, limit;
   logic [lpr_pkg::COUNT_BITS-1:0] fc_new;

   // A setting of zero acts as one frame and anything above the table size as all frames.
   always_comb begin
      if (frames_ff == '0) begin
         n_eff = lpr_pkg::FRAMES_ONE;
      end else if (frames_ff > lpr_pkg::FRAMES_CFG) begin
         n_eff = lpr_pkg::FRAMES_CFG;
      end else begin
         n_eff = frames_ff;
      end
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         managed[j] = (lpr_pkg::CFG_BITS'(j) < n_eff);
      end
   end

   // Lookup: tag compare, empty frames and per-group oldest frame.
   always_comb begin
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         match_in[j] = managed[j] && valid_ff[j] && (page_ff[j] == in_page_ff);
         empty_in[j] = managed[j] && !valid_ff[j];
      end
      for (int g = 0; g < lpr_pkg::GROUPS; g++) begin
         grp_best_in[g] = '0;
         grp_idx_in[g]  = FB'(g * lpr_pkg::GROUP_SIZE);
         for (int i = 0; i < lpr_pkg::GROUP_SIZE; i++) begin
            if (managed[g * lpr_pkg::GROUP_SIZE + i] &&
                rank_ff[g * lpr_pkg::GROUP_SIZE + i] > grp_best_in[g]) begin
               grp_best_in[g] = rank_ff[g * lpr_pkg::GROUP_SIZE + i];
               grp_idx_in[g]  = FB'(g * lpr_pkg::GROUP_SIZE + i);
            end
         end
      end
   end

   // Update: pick the frame, age frames below the limit (all on a fill), clear on last.
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int j = lpr_pkg::FRAMES - 1; j >= 0; j--) begin
         if (match_ff[j]) hit_idx = FB'(j);
         if (empty_ff[j]) empty_idx = FB'(j);
      end
      hit_any   = |match_ff;
      empty_any = |empty_ff;

      // Ties go to the lower group, so the lowest-numbered oldest frame wins.
      victim_best = grp_best_ff[0];
      victim_idx  = grp_idx_ff[0];
      for (int g = 1; g < lpr_pkg::GROUPS; g++) begin
         if (grp_best_ff[g] > victim_best) begin
            victim_best = grp_best_ff[g];
            victim_idx  = grp_idx_ff[g];
         end
      end

      evict     = !hit_any && !empty_any;
      limit_all = !hit_any && empty_any;
      if (hit_any) begin
         slot  = hit_idx;
         limit = rank_ff[hit_idx];
      end else if (empty_any) begin
         slot  = empty_idx;
         limit = victim_best;
      end else begin
         slot  = victim_idx;
         limit = victim_best;
      end

      if (hit_any || faults_ff == lpr_pkg::COUNT_MAX) begin
         fc_new = faults_ff;
      end else begin
         fc_new = faults_ff + 1'b1;
      end

      valid_in  = valid_ff;
      faults_in = faults_ff;
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         rank_in[j] = rank_ff[j];
      end
      if (cmd.update) begin
         if (in_last_ff) begin
            valid_in  = '0;
            faults_in = '0;
            for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
               rank_in[j] = '0;
            end
         end else begin
            faults_in       = fc_new;
            valid_in[slot]  = 1'b1;
            for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
               if (FB'(j) == slot) begin
                  rank_in[j] = '0;
               end else if (managed[j] && valid_ff[j] && rank_ff[j] != lpr_pkg::RANK_MAX &&
                            (limit_all || rank_ff[j] < limit)) begin
                  rank_in[j] = rank_ff[j] + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      frames_in = frames_ff;
      if (csr_wr_en) frames_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         faults_ff <= '0;
         frames_ff <= lpr_pkg::FRAMES_CFG;
         for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         faults_ff <= faults_in;
         frames_ff <= frames_in;
         for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
      end
   end

   // Page numbers have no reset; a frame is only compared while it is valid.
   always_ff @(posedge clock) begin
      if (cmd.update && !hit_any) page_ff[slot] <= in_page_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_page_ff <= req_page_number;
         in_last_ff <= req_last_reference;
      end
      if (cmd.lookup) begin
         match_ff <= match_in;
         empty_ff <= empty_in;
         for (int g = 0; g < lpr_pkg::GROUPS; g++) begin
            grp_best_ff[g] <= grp_best_in[g];
            grp_idx_ff[g]  <= grp_idx_in[g];
         end
      end
      if (cmd.update) begin
         hit_out_ff <= hit_any;
         idx_out_ff <= slot;
         ev_out_ff  <= evict;
         evp_out_ff <= evict ? page_ff[victim_idx] : '0;
         fc_out_ff  <= fc_new;
      end
   end

   assign rsp_hit           = hit_out_ff;
   assign rsp_frame_index   = idx_out_ff;
   assign rsp_evicted_valid = ev_out_ff;
   assign rsp_evicted_page  = evp_out_ff;
   assign rsp_fault_count   = fc_out_ff;

   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !in_last_ff) |=> valid_ff[idx_out_ff])
      else $error("referenced frame not valid after update");

   a_slot_newest: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !in_last_ff) |=> rank_ff[idx_out_ff] == '0)
      else $error("referenced frame not most recent after update");

   a_miss_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !hit_any) |=> fc_out_ff != '0)
      else $error("fault not counted");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && hit_any) |=> (!ev_out_ff && evp_out_ff == '0))
      else $error("eviction reported on a hit");

endmodule

// ===== design/lru_page_replacement_top.sv =====
// LRU page replacement: one page reference in, one placement result out per request.
//
// The req_ch channel carries a page number and a last-reference flag; the rsp_ch
// channel returns hit, the frame that now holds the page, the evicted page (if any)
// and the saturating fault count of the current reference string. Both channels use
// a valid/ready handshake. The csr port writes frames_in_use, the number of frames
// managed (0 acts as 1, above 16 acts as 16); write it only while the block is idle.
// A request passes through capture, a lookup state that registers the tag compares
// and the oldest frame of each group of four, and an update state that commits the
// frame table and loads the response register. A new request is not accepted until
// the previous one has left the update state, but one is accepted while a response
// waits; if the receiver stalls, the update state holds until the response register
// is free. After a request flagged as last reference, all frames, ranks and the fault
// count are cleared. Reset empties all frames, clears the count and sets frames_in_use
// to 16; no clearing pass is needed.
module lru_page_replacement_top (
   input  logic                         clock,
   input  logic                         reset,
   lpr_req_if.sink                      req_ch,
   lpr_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [lpr_pkg::CFG_BITS-1:0] csr_wr_data
);

   lpr_pkg::lpr_cmd_type cmd;
   logic                 req_ready;
   logic                 rsp_valid;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   lpr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_page_number    (req_ch.page_number),
      .req_last_reference (req_ch.last_reference),
      .rsp_hit            (rsp_ch.hit),
      .rsp_frame_index    (rsp_ch.frame_index),
      .rsp_evicted_valid  (rsp_ch.evicted_valid),
      .rsp_evicted_page   (rsp_ch.evicted_page),
      .rsp_fault_count    (rsp_ch.fault_count)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

// ===== dv/lru_page_replacement_top_tb.sv =====
// Self-checking testbench for the LRU page replacement block.
module lru_page_replacement_top_tb;

   typedef struct packed {
      logic                           hit;
      logic [lpr_pkg::FRAME_BITS-1:0] frame_index;
      logic                           evicted_valid;
      logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page;
      logic [lpr_pkg::COUNT_BITS-1:0] fault_count;
   } placement_type;

   typedef struct packed {
      logic                          set_cfg;
      logic [lpr_pkg::CFG_BITS-1:0]  cfg;
      logic [lpr_pkg::PAGE_BITS-1:0] page;
      logic                          last;
      logic                          typed;
      placement_type                 res;
   } script_row_type;

   localparam int SCRIPT_ROWS = 19;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // cfg?  cfg    page      last  typed   hit  frame ev    evicted    faults
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd1}},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd2}},
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd2}},
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2}},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd1}},
      '{1'b1, 5'd2,  16'h1234, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd2}},
      '{1'b0, 5'd0,  16'h5678, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'hFFFF, 16'd3}},
      '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b0, '0},
      '{1'b1, 5'd0,  16'hAAAA, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h5678, 16'd4}},
      '{1'b0, 5'd0,  16'h1234, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b1, 16'hAAAA, 16'd5}},
      '{1'b1, 5'd31, 16'h8000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd1}},
      '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h8000, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0001, 1'b1, 1'b0, '0},
      '{1'b1, 5'd1,  16'h0011, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd1}},
      '{1'b1, 5'd2,  16'h0022, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd2}},
      '{1'b1, 5'd1,  16'h0033, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0011, 16'd3}},
      '{1'b1, 5'd3,  16'h0044, 1'b0, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 16'd4}},
      '{1'b1, 5'd2,  16'h0055, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0033, 16'd5}}
   };

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 50;
   localparam logic [lpr_pkg::CFG_BITS-1:0] PHASE_FRAMES [PHASES] = '{
      5'd3, 5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd7, 5'd12
   };
   localparam int POOL        = 20;
   localparam int SETTLE      = 6;
   localparam int LONG_HOLD   = 60;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset;
   logic                         csr_wr_en;
   logic [lpr_pkg::CFG_BITS-1:0] csr_wr_data;

   lpr_req_if req_if ();
   lpr_rsp_if rsp_if ();

   lru_page_replacement_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the frame table.
   logic [lpr_pkg::PAGE_BITS-1:0]  resident_page  [lpr_pkg::FRAMES];
   logic                           resident_valid [lpr_pkg::FRAMES];
   int                             recency        [lpr_pkg::FRAMES];
   logic [lpr_pkg::COUNT_BITS-1:0] fault_tally;
   logic [lpr_pkg::CFG_BITS-1:0]   managed_cfg;

   placement_type pending_placements [$];
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  stall_left     = 0;
   bit  hold_wanted    = 1'b0;
   bit  hold_done      = 1'b0;
   bit  steady_source  = 1'b0;
   bit  steady_sink    = 1'b0;
   logic [lpr_pkg::PAGE_BITS-1:0] page_pool [POOL];

   function automatic void wipe_frames();
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         resident_page[j]  = '0;
         resident_valid[j] = 1'b0;
         recency[j]        = 0;
      end
      fault_tally = '0;
   endfunction

   // Frame x becomes the most recent; valid managed frames younger than limit age by one.
   function automatic void promote(input int n, input int x, input int limit);
      for (int j = 0; j < n; j++) begin
         if (j != x && resident_valid[j] && recency[j] < limit &&
             recency[j] < lpr_pkg::FRAMES - 1)
            recency[j]++;
      end
      recency[x] = 0;
   endfunction

   function automatic placement_type place_page(input logic [lpr_pkg::PAGE_BITS-1:0] page,
                                                input logic last);
      placement_type res;
      int n, slot, best;
      bit hit, found;
      res   = '0;
      hit   = 1'b0;
      found = 1'b0;
      slot  = 0;
      n = (managed_cfg == 0) ? 1 :
          ((managed_cfg > lpr_pkg::FRAMES) ? lpr_pkg::FRAMES : int'(managed_cfg));
      for (int j = 0; j < n; j++) begin
         if (!hit && resident_valid[j] && resident_page[j] == page) begin
            hit  = 1'b1;
            slot = j;
         end
      end
      if (hit) begin
         promote(n, slot, recency[slot]);
      end else begin
         for (int j = 0; j < n; j++) begin
            if (!found && !resident_valid[j]) begin
               found = 1'b1;
               slot  = j;
            end
         end
         if (found) begin
            resident_page[slot]  = page;
            resident_valid[slot] = 1'b1;
            promote(n, slot, lpr_pkg::FRAMES);
         end else begin
            // Strictly greater keeps the lowest-numbered frame on a rank tie.
            best = 0;
            slot = 0;
            for (int j = 0; j < n; j++) begin
               if (recency[j] > best) begin
                  best = recency[j];
                  slot = j;
               end
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = resident_page[slot];
            resident_page[slot] = page;
            promote(n, slot, best);
         end
         if (fault_tally != lpr_pkg::COUNT_MAX)
            fault_tally++;
      end
      res.hit         = hit;
      res.frame_index = lpr_pkg::FRAME_BITS'(slot);
      res.fault_count = fault_tally;
      if (last)
         wipe_frames();
      return res;
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15)
         return $urandom_range(1, 2);
      if (r < 19)
         return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic int next_gap();
      if (steady_source || $urandom_range(0, 2) != 0)
         return 0;
      return idle_span();
   endfunction

   // Offers one request, records its placement once accepted, then maybe idles.
   task automatic issue(input logic [lpr_pkg::PAGE_BITS-1:0] page, input logic last,
                        input logic typed, input placement_type typed_res);
      placement_type predicted;
      int gap;
      req_if.valid          <= 1'b1;
      req_if.page_number    <= page;
      req_if.last_reference <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = place_page(page, last);
      pending_placements.push_back(typed ? typed_res : predicted);
      gap = next_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_placements.size() != 0);
   endtask

   task automatic program_frames(input logic [lpr_pkg::CFG_BITS-1:0] value);
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      managed_cfg = value;
   endtask

   always @(posedge clock) begin : check_results
      placement_type got, want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = '{rsp_if.hit, rsp_if.frame_index, rsp_if.evicted_valid,
                 rsp_if.evicted_page, rsp_if.fault_count};
         if (pending_placements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: hit=%0d frame=%0d evicted=%0d/%h faults=%0d",
                        got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                        got.fault_count);
         end else begin
            want = pending_placements.pop_front();
            if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
                got.evicted_valid !== want.evicted_valid ||
                got.evicted_page !== want.evicted_page ||
                got.fault_count !== want.fault_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"response mismatch: expected hit=%0d frame=%0d evicted=%0d/%h ",
                            "faults=%0d, got hit=%0d frame=%0d evicted=%0d/%h faults=%0d"},
                           want.hit, want.frame_index, want.evicted_valid, want.evicted_page,
                           want.fault_count, got.hit, got.frame_index, got.evicted_valid,
                           got.evicted_page, got.fault_count);
            end
         end
      end
   end

   // Response side: random stalls, steady stretches, and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= LONG_HOLD;
         hold_done    <= 1'b1;
      end else if (steady_sink || $urandom_range(0, 3) != 0) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= 1'b0;
         stall_left   <= idle_span() - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [lpr_pkg::PAGE_BITS-1:0] page;
      logic                          last;
      int                            span;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.page_number    = '0;
      req_if.last_reference = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      wipe_frames();
      managed_cfg = lpr_pkg::FRAMES_CFG;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < POOL; i++)
         page_pool[i] = lpr_pkg::PAGE_BITS'($urandom_range(0, 65535));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (SCRIPT[r].set_cfg)
            program_frames(SCRIPT[r].cfg);
         issue(SCRIPT[r].page, SCRIPT[r].last, SCRIPT[r].typed, SCRIPT[r].res);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         program_frames(ph == PHASES - 1 ? lpr_pkg::CFG_BITS'($urandom_range(0, 31)) :
                                           PHASE_FRAMES[ph]);
         steady_source = (ph == 2 || ph == 3);
         steady_sink   = (ph == 5);
         // The sink holds off for a long stretch while requests keep coming.
         if (ph == 2)
            hold_wanted = 1'b1;
         span = int'($urandom_range(1, POOL));
         for (int i = 2; i < POOL; i++) begin
            if ($urandom_range(0, 3) == 0)
               page_pool[i] = lpr_pkg::PAGE_BITS'($urandom_range(0, 65535));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 9) == 0)
               page = lpr_pkg::PAGE_BITS'($urandom_range(0, 65535));
            else
               page = page_pool[$urandom_range(0, span - 1)];
            last = ($urandom_range(0, 39) == 0);
            issue(page, last, 1'b0, '0);
            if ($urandom_range(0, 59) == 0)
               wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_placements.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
